// ===== design/multi_channel_periodic_tick_timer_unit_defines.svh =====
// Assertion macros for the periodic tick timer pool.
// Used by the controller and datapath; expects aclk and aresetn in scope.
`ifndef MULTI_CHANNEL_PERIODIC_TICK_TIMER_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_PERIODIC_TICK_TIMER_UNIT_DEFINES_SVH

// same-cycle implication
`define MCTT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MCTT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mctt_pkg.sv =====
// Shared types and constants for the periodic tick timer pool.
// No dependencies.
package mctt_pkg;

    localparam int CHANNELS       = 4;
    localparam int CH_BITS        = 2;
    localparam int CATCH_UP_LIMIT = 1000;
    localparam int TIME_BITS      = 48;
    localparam int PERIOD_BITS    = 32;
    localparam int COUNT_BITS     = 32;
    localparam int FIRED_BITS     = 10;
    localparam int FIRE_BITS      = $clog2(CATCH_UP_LIMIT + 2);
    localparam int STATUS_BITS    = 2;
    localparam logic [PERIOD_BITS-1:0] DEFAULT_PERIOD = PERIOD_BITS'(1000);

    typedef enum logic [2:0] {
        OP_CREATE   = 3'd0,
        OP_DESTROY  = 3'd1,
        OP_START    = 3'd2,
        OP_RESTART  = 3'd3,
        OP_STOP     = 3'd4,
        OP_POLL_ONE = 3'd5,
        OP_POLL_ALL = 3'd6
    } opcode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STS_OK        = 2'd0,
        STS_NO_FREE   = 2'd1,
        STS_NOT_ALLOC = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SINGLE,
        ST_SCAN,
        ST_POLL,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_CHAN,
        CUR_FREE,
        CUR_ZERO,
        CUR_INCR
    } cur_sel_t;

    typedef struct packed {
        logic     load_in;
        cur_sel_t cur_sel;
        logic     poll_init;
        logic     poll_step;
        logic     emit_single;
        logic     emit_poll;
    } ctrl_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    occ_cur;
        logic    cur_is_max;
        logic    any_above;
        logic    step_hit;
        logic    step_final;
        logic    out_free;
    } dp_sts_t;

endpackage

// ===== design/mctt_ctrl.sv =====
// Sequencing state machine for the periodic tick timer pool.
// Depends on mctt_pkg and the defines header.
`include "multi_channel_periodic_tick_timer_unit_defines.svh"

module mctt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mctt_pkg::dp_sts_t  sts,
    output mctt_pkg::ctrl_cmd_t cmd
);

    mctt_pkg::state_t state_reg;
    mctt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mctt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mctt_pkg::ST_IDLE: begin
                if (s_valid) state_next = mctt_pkg::ST_DECODE;
            end
            mctt_pkg::ST_DECODE: begin
                unique case (sts.op) inside
                    mctt_pkg::OP_CREATE, mctt_pkg::OP_DESTROY, mctt_pkg::OP_START,
                    mctt_pkg::OP_RESTART, mctt_pkg::OP_STOP:
                        state_next = mctt_pkg::ST_SINGLE;
                    mctt_pkg::OP_POLL_ONE, mctt_pkg::OP_POLL_ALL:
                        state_next = mctt_pkg::ST_SCAN;
                    default: state_next = mctt_pkg::ST_IDLE;
                endcase
            end
            mctt_pkg::ST_SINGLE: begin
                if (sts.out_free) state_next = mctt_pkg::ST_IDLE;
            end
            mctt_pkg::ST_SCAN: begin
                if (sts.occ_cur) begin
                    state_next = mctt_pkg::ST_POLL;
                end else if (sts.op == mctt_pkg::OP_POLL_ONE) begin
                    state_next = mctt_pkg::ST_SINGLE;
                end else if (sts.cur_is_max) begin
                    state_next = mctt_pkg::ST_IDLE;
                end
            end
            mctt_pkg::ST_POLL: begin
                if (!sts.step_hit || sts.step_final) state_next = mctt_pkg::ST_EMIT;
            end
            mctt_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    if (sts.op == mctt_pkg::OP_POLL_ONE || !sts.any_above) begin
                        state_next = mctt_pkg::ST_IDLE;
                    end else begin
                        state_next = mctt_pkg::ST_SCAN;
                    end
                end
            end
            default: state_next = mctt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.cur_sel = mctt_pkg::CUR_HOLD;
        s_ready     = 1'b0;
        unique case (state_reg)
            mctt_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            mctt_pkg::ST_DECODE: begin
                unique case (sts.op)
                    mctt_pkg::OP_CREATE:   cmd.cur_sel = mctt_pkg::CUR_FREE;
                    mctt_pkg::OP_POLL_ALL: cmd.cur_sel = mctt_pkg::CUR_ZERO;
                    default:               cmd.cur_sel = mctt_pkg::CUR_CHAN;
                endcase
            end
            mctt_pkg::ST_SINGLE: begin
                cmd.emit_single = sts.out_free;
            end
            mctt_pkg::ST_SCAN: begin
                if (sts.occ_cur) begin
                    cmd.poll_init = 1'b1;
                end else if (sts.op != mctt_pkg::OP_POLL_ONE && !sts.cur_is_max) begin
                    cmd.cur_sel = mctt_pkg::CUR_INCR;
                end
            end
            mctt_pkg::ST_POLL: begin
                cmd.poll_step = sts.step_hit;
            end
            mctt_pkg::ST_EMIT: begin
                cmd.emit_poll = sts.out_free;
                if (sts.out_free && sts.op == mctt_pkg::OP_POLL_ALL && sts.any_above) begin
                    cmd.cur_sel = mctt_pkg::CUR_INCR;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    `MCTT_ASSERT_IMP(a_emit_needs_room, cmd.emit_single || cmd.emit_poll, sts.out_free, "emit while output word still held")
    `MCTT_ASSERT_NXT(a_load_to_decode, cmd.load_in, state_reg == mctt_pkg::ST_DECODE, "accepted word not decoded")
    `MCTT_ASSERT_NXT(a_poll_ends, state_reg == mctt_pkg::ST_POLL && !sts.step_hit, state_reg == mctt_pkg::ST_EMIT, "poll did not stop on missed deadline")

endmodule

// ===== design/mctt_dp.sv =====
// Datapath of the periodic tick timer pool: channel state, catch-up
// adder/comparator and output register. Depends on mctt_pkg and the defines header.
`include "multi_channel_periodic_tick_timer_unit_defines.svh"

module mctt_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [2:0]                            s_opcode,
    input  logic [mctt_pkg::CH_BITS-1:0]          s_channel,
    input  logic [mctt_pkg::PERIOD_BITS-1:0]      s_period_us,
    input  logic [mctt_pkg::TIME_BITS-1:0]        s_now_us,
    input  mctt_pkg::ctrl_cmd_t                   cmd,
    output mctt_pkg::dp_sts_t                     sts,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mctt_pkg::CH_BITS-1:0]          m_result_channel,
    output logic [mctt_pkg::STATUS_BITS-1:0]      m_status,
    output logic [mctt_pkg::FIRED_BITS-1:0]       m_ticks_fired,
    output logic [mctt_pkg::COUNT_BITS-1:0]       m_tick_count,
    output logic                                  m_resynced,
    output logic                                  m_last
);

    localparam int CHB = mctt_pkg::CH_BITS;
    localparam int TB  = mctt_pkg::TIME_BITS;
    localparam int PB  = mctt_pkg::PERIOD_BITS;
    localparam int CB  = mctt_pkg::COUNT_BITS;
    localparam int FB  = mctt_pkg::FIRE_BITS;
    localparam logic [FB-1:0] FIRE_LIMIT = FB'(mctt_pkg::CATCH_UP_LIMIT);
    localparam logic [FB-1:0] FIRE_MAX   = FB'(mctt_pkg::CATCH_UP_LIMIT + 1);

    mctt_pkg::opcode_t op_reg;
    logic [CHB-1:0]    ch_reg;
    logic [PB-1:0]     period_in_reg;
    logic [TB-1:0]     now_reg;
    logic [CHB-1:0]    cur_reg;
    logic [CHB-1:0]    cur_next;
    logic [FB-1:0]     fired_reg;
    logic              rs_reg;

    logic [mctt_pkg::CHANNELS-1:0] occ_reg;
    logic [mctt_pkg::CHANNELS-1:0] run_reg;
    logic [PB-1:0] period_reg   [mctt_pkg::CHANNELS];
    logic [TB-1:0] deadline_reg [mctt_pkg::CHANNELS];
    logic [CB-1:0] count_reg    [mctt_pkg::CHANNELS];

    logic              out_valid_reg;
    logic [CHB-1:0]    out_ch_reg;
    mctt_pkg::status_t out_status_reg;
    logic [FB-1:0]     out_fired_reg;
    logic [CB-1:0]     out_count_reg;
    logic              out_rs_reg;
    logic              out_last_reg;

    logic              free_found;
    logic [CHB-1:0]    free_idx;
    logic              any_above;
    logic              step_hit;
    logic              step_final;
    logic              out_free;
    logic [TB-1:0]     period_ext;
    logic [TB-1:0]     now_plus_period;
    logic [TB-1:0]     deadline_plus_period;
    mctt_pkg::status_t single_status;
    logic [CHB-1:0]    single_ch;
    logic [CB-1:0]     single_count;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = mctt_pkg::CHANNELS - 1; i >= 0; i--) begin
            if (!occ_reg[i]) begin
                free_found = 1'b1;
                free_idx   = CHB'(i);
            end
        end
    end

    always_comb begin
        any_above = 1'b0;
        for (int i = 0; i < mctt_pkg::CHANNELS; i++) begin
            if (CHB'(i) > cur_reg && occ_reg[i]) any_above = 1'b1;
        end
    end

    assign period_ext           = TB'(period_reg[cur_reg]);
    assign now_plus_period      = now_reg + period_ext;
    assign deadline_plus_period = deadline_reg[cur_reg] + period_ext;
    assign step_hit             = run_reg[cur_reg] && (now_reg >= deadline_reg[cur_reg]);
    assign step_final           = step_hit && (fired_reg >= FIRE_LIMIT);
    assign out_free             = !out_valid_reg || m_ready;

    assign sts.op         = op_reg;
    assign sts.occ_cur    = occ_reg[cur_reg];
    assign sts.cur_is_max = (cur_reg == CHB'(mctt_pkg::CHANNELS - 1));
    assign sts.any_above  = any_above;
    assign sts.step_hit   = step_hit;
    assign sts.step_final = step_final;
    assign sts.out_free   = out_free;

    always_comb begin
        single_ch     = cur_reg;
        single_status = mctt_pkg::STS_OK;
        single_count  = '0;
        if (op_reg == mctt_pkg::OP_CREATE) begin
            if (!free_found) single_status = mctt_pkg::STS_NO_FREE;
        end else if (!occ_reg[cur_reg]) begin
            single_status = mctt_pkg::STS_NOT_ALLOC;
        end else if (op_reg == mctt_pkg::OP_DESTROY) begin
            single_count = count_reg[cur_reg];
        end
    end

    always_comb begin
        case (cmd.cur_sel)
            mctt_pkg::CUR_CHAN: cur_next = ch_reg;
            mctt_pkg::CUR_FREE: cur_next = free_idx;
            mctt_pkg::CUR_ZERO: cur_next = '0;
            mctt_pkg::CUR_INCR: cur_next = cur_reg + CHB'(1);
            default:            cur_next = cur_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg        <= mctt_pkg::opcode_t'(s_opcode);
            ch_reg        <= s_channel;
            period_in_reg <= s_period_us;
            now_reg       <= s_now_us;
        end
        cur_reg <= cur_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fired_reg <= '0;
            rs_reg    <= 1'b0;
        end else if (cmd.poll_init) begin
            fired_reg <= '0;
            rs_reg    <= 1'b0;
        end else if (cmd.poll_step) begin
            fired_reg <= fired_reg + FB'(1);
            if (step_final) rs_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
            run_reg <= '0;
        end else if (cmd.emit_single) begin
            unique case (op_reg)
                mctt_pkg::OP_CREATE: begin
                    if (free_found) begin
                        occ_reg[cur_reg] <= 1'b1;
                        run_reg[cur_reg] <= 1'b0;
                    end
                end
                mctt_pkg::OP_DESTROY: begin
                    if (occ_reg[cur_reg]) begin
                        occ_reg[cur_reg] <= 1'b0;
                        run_reg[cur_reg] <= 1'b0;
                    end
                end
                mctt_pkg::OP_START: begin
                    if (occ_reg[cur_reg]) run_reg[cur_reg] <= 1'b1;
                end
                mctt_pkg::OP_STOP: begin
                    if (occ_reg[cur_reg]) run_reg[cur_reg] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_single) begin
            if (op_reg == mctt_pkg::OP_CREATE) begin
                if (free_found) begin
                    period_reg[cur_reg]   <= (period_in_reg == '0) ? mctt_pkg::DEFAULT_PERIOD
                                                                  : period_in_reg;
                    deadline_reg[cur_reg] <= '0;
                    count_reg[cur_reg]    <= '0;
                end
            end else if (occ_reg[cur_reg]) begin
                if (op_reg == mctt_pkg::OP_START || op_reg == mctt_pkg::OP_RESTART) begin
                    count_reg[cur_reg]    <= '0;
                    deadline_reg[cur_reg] <= now_plus_period;
                end else if (op_reg == mctt_pkg::OP_STOP) begin
                    count_reg[cur_reg]    <= '0;
                end
            end
        end else if (cmd.poll_step) begin
            count_reg[cur_reg]    <= count_reg[cur_reg] + CB'(1);
            deadline_reg[cur_reg] <= step_final ? now_plus_period : deadline_plus_period;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_single || cmd.emit_poll) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_single) begin
            out_ch_reg     <= single_ch;
            out_status_reg <= single_status;
            out_fired_reg  <= '0;
            out_count_reg  <= single_count;
            out_rs_reg     <= 1'b0;
            out_last_reg   <= 1'b1;
        end else if (cmd.emit_poll) begin
            out_ch_reg     <= cur_reg;
            out_status_reg <= mctt_pkg::STS_OK;
            out_fired_reg  <= fired_reg;
            out_count_reg  <= count_reg[cur_reg];
            out_rs_reg     <= rs_reg;
            out_last_reg   <= (op_reg == mctt_pkg::OP_POLL_ONE) || !any_above;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_result_channel = out_ch_reg;
    assign m_status         = out_status_reg;
    assign m_ticks_fired    = mctt_pkg::FIRED_BITS'(out_fired_reg);
    assign m_tick_count     = out_count_reg;
    assign m_resynced       = out_rs_reg;
    assign m_last           = out_last_reg;

    `MCTT_ASSERT_IMP(a_fired_bound, 1'b1, fired_reg <= FIRE_MAX, "catch-up count past limit")
    `MCTT_ASSERT_IMP(a_resync_at_limit, rs_reg, fired_reg == FIRE_MAX, "resync flagged below limit")
    `MCTT_ASSERT_NXT(a_final_sets_resync, cmd.poll_step && step_final, rs_reg, "limit reached without resync")

endmodule

// ===== design/multi_channel_periodic_tick_timer_unit.sv =====
// Sequence from the accepting edge to the result in the output register: create, destroy, start,
// restart and stop pass decode and single; poll one passes decode and scan, then single on a free
// channel, else poll, firing each elapsed tick up to a resync, and emit. A held output register
// stalls the sequence. Poll all: decode, then scan the channels in order, polling and emitting each
// occupied one. One word in flight: the next is accepted only after the final result is loaded.
// Synchronous active-low reset frees and stops every channel; channel state is set on create.
module multi_channel_periodic_tick_timer_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [2:0]                           s_opcode,
    input  logic [mctt_pkg::CH_BITS-1:0]         s_channel,
    input  logic [mctt_pkg::PERIOD_BITS-1:0]     s_period_us,
    input  logic [mctt_pkg::TIME_BITS-1:0]       s_now_us,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mctt_pkg::CH_BITS-1:0]         m_result_channel,
    output logic [mctt_pkg::STATUS_BITS-1:0]     m_status,
    output logic [mctt_pkg::FIRED_BITS-1:0]      m_ticks_fired,
    output logic [mctt_pkg::COUNT_BITS-1:0]      m_tick_count,
    output logic                                 m_resynced,
    output logic                                 m_last
);

    mctt_pkg::ctrl_cmd_t cmd;
    mctt_pkg::dp_sts_t   sts;

    mctt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mctt_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_opcode         (s_opcode),
        .s_channel        (s_channel),
        .s_period_us      (s_period_us),
        .s_now_us         (s_now_us),
        .cmd              (cmd),
        .sts              (sts),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_channel (m_result_channel),
        .m_status         (m_status),
        .m_ticks_fired    (m_ticks_fired),
        .m_tick_count     (m_tick_count),
        .m_resynced       (m_resynced),
        .m_last           (m_last)
    );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the periodic tick timer pool.
// Depends on mctt_pkg and multi_channel_periodic_tick_timer_unit; holds its own
// predictor in a small scoreboard class and drives all four channels from plain tasks.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBITS = mctt_pkg::TIME_BITS;
    localparam int CBITS = mctt_pkg::CH_BITS;
    localparam int PBITS = mctt_pkg::PERIOD_BITS;
    localparam int NCH   = mctt_pkg::CHANNELS;

    localparam logic [2:0]       OP_UNDEF     = 3'd7;
    localparam logic [TBITS-1:0] T_MAX        = {TBITS{1'b1}};
    localparam int               RANDOM_WORDS = 400;
    localparam int               QUIET_WORDS  = 80;
    localparam int               HOLD_CYCLES  = 400;
    localparam int               STALL_LIMIT  = 12000;

    typedef struct packed {
        logic [CBITS-1:0]                 chan;
        mctt_pkg::status_t                status;
        logic [mctt_pkg::FIRED_BITS-1:0]  fired;
        logic [mctt_pkg::COUNT_BITS-1:0]  count;
        logic                             resync;
        logic                             last;
    } timer_result_t;

    class tick_pool_scoreboard;
        bit                               occupied [NCH];
        bit                               running  [NCH];
        logic [PBITS-1:0]                 period   [NCH];
        logic [TBITS-1:0]                 deadline [NCH];
        logic [mctt_pkg::COUNT_BITS-1:0]  count    [NCH];
        timer_result_t                    expected_results [$];
        int                               errors;
        int                               checked;
        int                               resyncs;
        int                               pool_full;
        int                               not_alloc;

        function new();
            foreach (occupied[i]) begin
                occupied[i] = 1'b0;
                running[i]  = 1'b0;
                period[i]   = '0;
                deadline[i] = '0;
                count[i]    = '0;
            end
            errors    = 0;
            checked   = 0;
            resyncs   = 0;
            pool_full = 0;
            not_alloc = 0;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        // fire every elapsed period, bounded catch-up then resync
        function timer_result_t run_poll(int c, logic [TBITS-1:0] now);
            timer_result_t r;
            int            fired;
            r        = '0;
            fired    = 0;
            r.chan   = CBITS'(c);
            r.status = mctt_pkg::STS_OK;
            if (running[c]) begin
                while (now >= deadline[c]) begin
                    count[c]    = count[c] + 1'b1;
                    deadline[c] = deadline[c] + TBITS'(period[c]);
                    fired++;
                    if (fired > mctt_pkg::CATCH_UP_LIMIT) begin
                        deadline[c] = now + TBITS'(period[c]);
                        r.resync    = 1'b1;
                        break;
                    end
                end
            end
            r.fired = mctt_pkg::FIRED_BITS'(fired);
            r.count = count[c];
            return r;
        endfunction

        function void note_request(logic [2:0] op, logic [CBITS-1:0] ch,
                                   logic [PBITS-1:0] per,
                                   logic [TBITS-1:0] now);
            timer_result_t r;
            int            i;
            int            first;
            r      = '0;
            r.last = 1'b1;
            case (op) inside
                mctt_pkg::OP_CREATE: begin
                    r.status = mctt_pkg::STS_NO_FREE;
                    for (i = 0; i < NCH; i++) begin
                        if (!occupied[i]) begin
                            occupied[i] = 1'b1;
                            period[i]   = (per != '0) ? per : mctt_pkg::DEFAULT_PERIOD;
                            running[i]  = 1'b0;
                            deadline[i] = '0;
                            count[i]    = '0;
                            r.chan      = CBITS'(i);
                            r.status    = mctt_pkg::STS_OK;
                            break;
                        end
                    end
                    expected_results.push_back(r);
                end
                mctt_pkg::OP_DESTROY, mctt_pkg::OP_START, mctt_pkg::OP_RESTART,
                mctt_pkg::OP_STOP, mctt_pkg::OP_POLL_ONE: begin
                    r.chan = ch;
                    if (!occupied[ch]) begin
                        r.status = mctt_pkg::STS_NOT_ALLOC;
                    end else if (op == mctt_pkg::OP_POLL_ONE) begin
                        r      = run_poll(ch, now);
                        r.last = 1'b1;
                    end else begin
                        if (op == mctt_pkg::OP_DESTROY) begin
                            occupied[ch] = 1'b0;
                            running[ch]  = 1'b0;
                        end else begin
                            count[ch] = '0;
                            if (op == mctt_pkg::OP_START)
                                running[ch] = 1'b1;
                            if (op == mctt_pkg::OP_STOP)
                                running[ch] = 1'b0;
                            else
                                deadline[ch] = now + TBITS'(period[ch]);
                        end
                        r.count = count[ch];
                    end
                    expected_results.push_back(r);
                end
                mctt_pkg::OP_POLL_ALL: begin
                    first = expected_results.size();
                    for (i = 0; i < NCH; i++) begin
                        if (occupied[i])
                            expected_results.push_back(run_poll(i, now));
                    end
                    if (expected_results.size() > first) begin
                        r      = expected_results.pop_back();
                        r.last = 1'b1;
                        expected_results.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(timer_result_t got);
            timer_result_t want;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual ch %0d status %0d",
                         $time, got.chan, got.status);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            compare_field("result_channel", want.chan, got.chan);
            compare_field("status", want.status, got.status);
            compare_field("ticks_fired", want.fired, got.fired);
            compare_field("tick_count", want.count, got.count);
            compare_field("resynced", want.resync, got.resync);
            compare_field("last", want.last, got.last);
            if (got.resync)
                resyncs++;
            if (got.status == mctt_pkg::STS_NO_FREE)
                pool_full++;
            if (got.status == mctt_pkg::STS_NOT_ALLOC)
                not_alloc++;
        endfunction
    endclass

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic [2:0]                        s_opcode;
    logic [CBITS-1:0]                  s_channel;
    logic [PBITS-1:0]                  s_period_us;
    logic [TBITS-1:0]                  s_now_us;
    logic                              m_valid;
    logic                              m_ready;
    logic [CBITS-1:0]                  m_result_channel;
    logic [mctt_pkg::STATUS_BITS-1:0]  m_status;
    logic [mctt_pkg::FIRED_BITS-1:0]   m_ticks_fired;
    logic [mctt_pkg::COUNT_BITS-1:0]   m_tick_count;
    logic                              m_resynced;
    logic                              m_last;

    tick_pool_scoreboard sb;
    bit                  idle_on;
    bit                  long_hold;
    int                  words_sent;

    multi_channel_periodic_tick_timer_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_channel        (s_channel),
        .s_period_us      (s_period_us),
        .s_now_us         (s_now_us),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_channel (m_result_channel),
        .m_status         (m_status),
        .m_ticks_fired    (m_ticks_fired),
        .m_tick_count     (m_tick_count),
        .m_resynced       (m_resynced),
        .m_last           (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // optional idle burst, then offer one word and hold it until taken
    task automatic send_word(input logic [2:0] op, input logic [CBITS-1:0] ch,
                             input logic [PBITS-1:0] per,
                             input logic [TBITS-1:0] now);
        int n;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 17);
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     = 1'b1;
        s_opcode    = op;
        s_channel   = ch;
        s_period_us = per;
        s_now_us    = now;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, ch, per, now);
        words_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    initial begin : receiver
        int n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                long_hold = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                n       = $urandom_range(1, 17);
                m_ready = 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    initial begin : result_monitor
        timer_result_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.chan   = m_result_channel;
                got.status = mctt_pkg::status_t'(m_status);
                got.fired  = m_ticks_fired;
                got.count  = m_tick_count;
                got.resync = m_resynced;
                got.last   = m_last;
                sb.check_result(got);
            end
        end
    end

    // spurious result words do not count as progress
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready)
                || (m_valid && m_ready && sb.outstanding() != 0))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, quiet);
        $display("tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [2:0]       op;
        logic [CBITS-1:0] ch;
        logic [PBITS-1:0] per;
        logic [TBITS-1:0] now_base;
        int               k;
        int               i;
        int               j;
        int               r;
        bit               found;

        sb          = new();
        idle_on     = 1'b1;
        long_hold   = 1'b0;
        words_sent  = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_opcode    = mctt_pkg::OP_CREATE;
        s_channel   = '0;
        s_period_us = '0;
        s_now_us    = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty pool, undefined opcode, then destroy, start, restart, stop and poll one on a free channel
        send_word(mctt_pkg::OP_POLL_ALL, 2'd0, 32'd0, 48'd0);
        send_word(OP_UNDEF, 2'd3, 32'hFFFF_FFFF, T_MAX);
        send_word(mctt_pkg::OP_DESTROY, 2'd3, 32'd0, 48'd0);
        send_word(mctt_pkg::OP_START, 2'd2, 32'd0, 48'd0);
        send_word(mctt_pkg::OP_RESTART, 2'd1, 32'd0, 48'd0);
        send_word(mctt_pkg::OP_STOP, 2'd0, 32'd0, 48'd0);
        send_word(mctt_pkg::OP_POLL_ONE, 2'd3, 32'd0, 48'd0);
        // fill the pool: default period, largest period, then one too many
        send_word(mctt_pkg::OP_CREATE, 2'd0, 32'd0, 48'd0);
        send_word(mctt_pkg::OP_CREATE, 2'd0, 32'hFFFF_FFFF, 48'd0);
        send_word(mctt_pkg::OP_CREATE, 2'd0, 32'd1, 48'd0);
        send_word(mctt_pkg::OP_CREATE, 2'd0, 32'd5, 48'd0);
        send_word(mctt_pkg::OP_CREATE, 2'd0, 32'd9, 48'd0);
        send_word(mctt_pkg::OP_POLL_ONE, 2'd0, 32'd0, 48'd50);
        send_word(mctt_pkg::OP_START, 2'd0, 32'd0, 48'd0);
        send_word(mctt_pkg::OP_POLL_ONE, 2'd0, 32'd0, 48'd3500);
        send_word(mctt_pkg::OP_RESTART, 2'd3, 32'd0, 48'd10);
        send_word(mctt_pkg::OP_START, 2'd2, 32'd0, 48'd100);
        send_word(mctt_pkg::OP_POLL_ALL, 2'd0, 32'd0, 48'd5000);
        // deadline wraps past the top of the time range
        send_word(mctt_pkg::OP_START, 2'd1, 32'd0, T_MAX - 48'd65535);
        send_word(mctt_pkg::OP_POLL_ONE, 2'd1, 32'd0, T_MAX);
        send_word(mctt_pkg::OP_STOP, 2'd0, 32'd0, 48'd6000);
        send_word(mctt_pkg::OP_DESTROY, 2'd2, 32'd0, 48'd0);
        send_word(mctt_pkg::OP_CREATE, 2'd0, 32'd7, 48'd0);
        send_word(mctt_pkg::OP_START, 2'd2, 32'd0, T_MAX - 48'd100);
        send_word(mctt_pkg::OP_POLL_ALL, 2'd0, 32'd0, T_MAX);

        now_base = 48'd100000;
        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (k == RANDOM_WORDS - QUIET_WORDS)
                idle_on = 1'b0;
            if (k == 100)
                long_hold = 1'b1;
            if (k == 200)
                drain_results();

            r = $urandom_range(0, 99);
            if (r < 12)
                op = mctt_pkg::OP_CREATE;
            else if (r < 20)
                op = mctt_pkg::OP_DESTROY;
            else if (r < 35)
                op = mctt_pkg::OP_START;
            else if (r < 43)
                op = mctt_pkg::OP_RESTART;
            else if (r < 49)
                op = mctt_pkg::OP_STOP;
            else if (r < 74)
                op = mctt_pkg::OP_POLL_ONE;
            else if (r < 97)
                op = mctt_pkg::OP_POLL_ALL;
            else
                op = OP_UNDEF;

            ch    = CBITS'($urandom_range(0, NCH - 1));
            found = 1'b0;
            if ($urandom_range(0, 99) < 85) begin
                j = $urandom_range(0, NCH - 1);
                for (i = 0; i < NCH; i++) begin
                    if (!found && sb.occupied[(j + i) % NCH]) begin
                        ch    = CBITS'((j + i) % NCH);
                        found = 1'b1;
                    end
                end
            end

            r = $urandom_range(0, 99);
            if (op != mctt_pkg::OP_CREATE || r >= 95)
                per = $urandom();
            else if (r < 70)
                per = PBITS'($urandom_range(1, 64));
            else if (r < 85)
                per = '0;
            else
                per = PBITS'($urandom_range(65, 5000));

            r = $urandom_range(0, 99);
            if (r < 3)
                now_base = {16'($urandom), 32'($urandom)};
            else if (r < 6)
                now_base += 48'($urandom_range(0, 2000000));
            else
                now_base += 48'($urandom_range(0, 300));

            send_word(op, ch, per, now_base);
        end

        drain_results();
        repeat (40) @(posedge aclk);

        $display("tb: %0d words sent, %0d results checked, %0d errors",
                 words_sent, sb.checked, sb.errors);
        $display("tb: %0d catch-up resyncs, %0d pool-full and %0d unallocated replies seen",
                 sb.resyncs, sb.pool_full, sb.not_alloc);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
